@@ rtl/go_to_goal_velocity_controller_core_macros.svh @@
// Assertion helpers used by the core RTL.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_CORE_MACROS_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_CORE_MACROS_SVH

// a implies b in the same cycle
`define GTG_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("gtg check failed");

// a implies b in the next cycle
`define GTG_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("gtg check failed");

`endif

@@ rtl/gtg_pkg.sv @@
package gtg_pkg;

    localparam int POS_W  = 32;
    localparam int QUAT_W = 16;
    localparam int TOL_W  = 31;
    localparam int LIN_W  = 16;
    localparam int ANG_W  = 17;

    // register indexes
    localparam logic [1:0] REG_GOAL_X = 2'd0;
    localparam logic [1:0] REG_GOAL_Y = 2'd1;
    localparam logic [1:0] REG_TOL    = 2'd2;

    // cordic datapath
    localparam int CIN_W = 34;   // atan2 operand width
    localparam int CW    = 44;   // x/y working width
    localparam int MW    = 41;   // magnitude width, normalized into [2^40, 2^41)
    localparam int ZW    = 24;   // angle accumulator, Q.20
    localparam int CORDIC_STEPS = 20;
    localparam int N_NORM   = 3;
    localparam int N_ITER   = CORDIC_STEPS / 2;
    localparam int CORD_LAT = 1 + N_NORM + N_ITER + 1;

    // sqrt datapath
    localparam int SQ_W     = 30;
    localparam int SQRT_LAT = 5;
    localparam int SQRT_PER = 3;

    // distance has to wait for the angle path
    localparam int DLY = (2 + CORD_LAT) - (3 + SQRT_LAT);

    localparam logic [LIN_W-1:0] HALF_M = 16'd32768;
    localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
    localparam logic signed [ANG_W-1:0] PI_Q13 = 17'sd25736;

    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
        24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
        24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
        24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [MW-1:0]        m;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cst;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sq;

    // shift left by s while the magnitude stays below 2^41
    function automatic t_cst norm_step(t_cst v, int s);
        t_cst o;
        o = v;
        if ((v.m >> (MW - s)) == '0) begin
            o.x = v.x <<< s;
            o.y = v.y <<< s;
            o.m = v.m << s;
        end
        return o;
    endfunction

    // one vectoring micro-rotation
    function automatic t_cst rot_step(t_cst v, int i);
        t_cst o;
        o = v;
        if (!v.y[CW-1]) begin
            o.x = v.x + (v.y >>> i);
            o.y = v.y - (v.x >>> i);
            o.z = v.z + ATAN_TAB[i];
        end else begin
            o.x = v.x - (v.y >>> i);
            o.y = v.y + (v.x >>> i);
            o.z = v.z - ATAN_TAB[i];
        end
        return o;
    endfunction

    // one digit of the restoring square root
    function automatic t_sq sq_step(t_sq s, int j);
        t_sq o;
        logic [SQ_W-1:0] b;
        logic [SQ_W:0] sum;
        o = s;
        b = SQ_W'(1) << (28 - 2 * j);
        sum = {1'b0, s.r} + {1'b0, b};
        if ({1'b0, s.v} >= sum) begin
            o.v = s.v - sum[SQ_W-1:0];
            o.r = (s.r >> 1) + b;
        end else begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage

@@ rtl/gtg_pose_if.sv @@
interface gtg_pose_if
    import gtg_pkg::*;
;
    logic valid;
    logic ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;

    modport source (output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    output ready);
endinterface

@@ rtl/gtg_cmd_if.sv @@
interface gtg_cmd_if
    import gtg_pkg::*;
;
    logic valid;
    logic ready;
    logic [LIN_W-1:0]        linear_speed;
    logic signed [ANG_W-1:0] angular_rate;
    logic                    moving;

    modport source (output valid, linear_speed, angular_rate, moving, input ready);
    modport sink   (input valid, linear_speed, angular_rate, moving, output ready);
endinterface

@@ rtl/gtg_sqrt.sv @@
module gtg_sqrt
    import gtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_big,
    input  logic [SQ_W-1:0]   i_d2,
    output logic [LIN_W-1:0]  o_dist
);

    t_sq  r_sq  [SQRT_LAT];
    logic r_big [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stg
        t_sq  w_in;
        t_sq  n_sq;
        logic w_big;
        if (k == 0) begin : g_first
            assign w_in  = {i_d2, {SQ_W{1'b0}}};
            assign w_big = i_big;
        end else begin : g_next
            assign w_in  = r_sq[k-1];
            assign w_big = r_big[k-1];
        end
        always_comb begin
            n_sq = w_in;
            for (int j = 0; j < SQRT_PER; j++) begin
                n_sq = sq_step(n_sq, k * SQRT_PER + j);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k]  <= n_sq;
                r_big[k] <= w_big;
            end
        end
    end

    assign o_dist = r_big[SQRT_LAT-1] ? HALF_M : r_sq[SQRT_LAT-1].r[LIN_W-1:0];

endmodule

@@ rtl/gtg_cordic.sv @@
module gtg_cordic
    import gtg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic signed [CIN_W-1:0] i_y,
    input  logic signed [CIN_W-1:0] i_x,
    output logic                    o_vld,
    output logic signed [ANG_W-1:0] o_ang
);

    logic [CORD_LAT-1:0]     r_vld;
    t_cst                    r_st [CORD_LAT-1];
    logic signed [ANG_W-1:0] r_ang;

    t_cst           n_pre;
    logic [CW-1:0]  w_ax;
    logic [CW-1:0]  w_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[CORD_LAT-2:0], i_vld};
        end
    end

    // fold left half plane, find the larger magnitude
    always_comb begin
        n_pre.x = CW'(i_x);
        n_pre.y = CW'(i_y);
        n_pre.z = '0;
        if (i_x[CIN_W-1]) begin
            n_pre.x = -n_pre.x;
            n_pre.y = -n_pre.y;
            n_pre.z = i_y[CIN_W-1] ? -PI_Q20 : PI_Q20;
        end
        w_ax = n_pre.x;
        w_ay = n_pre.y[CW-1] ? -n_pre.y : n_pre.y;
        n_pre.m = (w_ax > w_ay) ? w_ax[MW-1:0] : w_ay[MW-1:0];
        n_pre.zero = (i_x == '0) && (i_y == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_pre;
        end
    end

    // stages 1..N_NORM normalize (two shifts each), the rest rotate twice
    for (genvar p = 1; p < CORD_LAT - 1; p++) begin : g_stg
        t_cst n_st;
        if (p <= N_NORM) begin : g_norm
            always_comb begin
                n_st = norm_step(norm_step(r_st[p-1], 32 >> (2 * (p - 1))),
                                 16 >> (2 * (p - 1)));
            end
        end else begin : g_rot
            always_comb begin
                n_st = rot_step(rot_step(r_st[p-1], 2 * (p - 1 - N_NORM)),
                                2 * (p - 1 - N_NORM) + 1);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[p] <= n_st;
            end
        end
    end

    // round Q.20 to Q3.13 and clamp to +-pi
    logic signed [ZW-1:0]    w_zr;
    logic signed [ANG_W-1:0] n_ang;

    always_comb begin
        w_zr  = r_st[CORD_LAT-2].z + 24'sd64;
        n_ang = ANG_W'(w_zr >>> 7);
        if (n_ang > PI_Q13) begin
            n_ang = PI_Q13;
        end else if (n_ang < -PI_Q13) begin
            n_ang = -PI_Q13;
        end
        if (r_st[CORD_LAT-2].zero) begin
            n_ang = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    assign o_vld = r_vld[CORD_LAT-1];
    assign o_ang = r_ang;

endmodule

@@ rtl/go_to_goal_velocity_controller_core.sv @@
// Channel   Dir  Payload                                        Beat when
// i_pose    in   pos_x, pos_y, quat_x, quat_y, quat_z, quat_w   valid && ready
// o_cmd     out  linear_speed, angular_rate, moving             valid && ready
// cfg       in   i_cfg_idx, i_cfg_data                          i_cfg_we
//
// One pose per cycle sustained while o_cmd takes each beat; the pipeline depth is set
// by the two 15 stage CORDIC atan2 pipelines (pre-fold, 3 normalize stages, 10 stages
// of two micro-rotations, round).
// Reset is synchronous, active low; it clears valid bits and the goal/tolerance regs.
// The whole pipeline advances together; when the output register holds an untaken
// beat, i_pose.ready drops and every stage holds.
`include "go_to_goal_velocity_controller_core_macros.svh"

module go_to_goal_velocity_controller_core
    import gtg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [POS_W-1:0] i_cfg_data,
    gtg_pose_if.sink         i_pose,
    gtg_cmd_if.source        o_cmd
);

    logic w_en;

    // configuration
    logic signed [POS_W-1:0] r_goal_x;
    logic signed [POS_W-1:0] r_goal_y;
    logic [TOL_W-1:0]        r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GOAL_X: r_goal_x <= i_cfg_data;
                REG_GOAL_Y: r_goal_y <= i_cfg_data;
                REG_TOL:    r_tol    <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic signed [POS_W-1:0] sat_diff(logic signed [POS_W-1:0] a,
                                                        logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        d = (POS_W+1)'(a) - (POS_W+1)'(b);
        if (d[POS_W] != d[POS_W-1]) begin
            return d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        return d[POS_W-1:0];
    endfunction

    // stage 1: offsets to goal, quaternion products
    logic                    r_v1;
    logic signed [POS_W-1:0] r_dx;
    logic signed [POS_W-1:0] r_dy;
    logic signed [31:0]      r_pwz;
    logic signed [31:0]      r_pxy;
    logic signed [31:0]      r_pyy;
    logic signed [31:0]      r_pzz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_pose.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx  <= sat_diff(r_goal_x, i_pose.pos_x);
            r_dy  <= sat_diff(r_goal_y, i_pose.pos_y);
            r_pwz <= 32'(i_pose.quat_w) * 32'(i_pose.quat_z);
            r_pxy <= 32'(i_pose.quat_x) * 32'(i_pose.quat_y);
            r_pyy <= 32'(i_pose.quat_y) * 32'(i_pose.quat_y);
            r_pzz <= 32'(i_pose.quat_z) * 32'(i_pose.quat_z);
        end
    end

    // stage 2: yaw operands, squared offsets
    logic                    r_v2;
    logic signed [CIN_W-1:0] r_num;
    logic signed [CIN_W-1:0] r_den;
    logic signed [CIN_W-1:0] r_bx;
    logic signed [CIN_W-1:0] r_by;
    logic [63:0]             r_sqx;
    logic [63:0]             r_sqy;
    logic [POS_W-1:0]        w_ax;
    logic [POS_W-1:0]        w_ay;

    assign w_ax = r_dx[POS_W-1] ? (~r_dx + 1'b1) : r_dx;
    assign w_ay = r_dy[POS_W-1] ? (~r_dy + 1'b1) : r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= (CIN_W'(r_pwz) + CIN_W'(r_pxy)) <<< 1;
            r_den <= (CIN_W'(1) <<< 28) - ((CIN_W'(r_pyy) + CIN_W'(r_pzz)) <<< 1);
            r_bx  <= CIN_W'(r_dx);
            r_by  <= CIN_W'(r_dy);
            r_sqx <= 64'(w_ax) * 64'(w_ax);
            r_sqy <= 64'(w_ay) * 64'(w_ay);
        end
    end

    // stage 3: squared distance, saturation flag
    logic [63:0]     w_d2;
    logic            r_big;
    logic [SQ_W-1:0] r_d2lo;

    assign w_d2 = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_big  <= |w_d2[63:SQ_W];
            r_d2lo <= w_d2[SQ_W-1:0];
        end
    end

    // distance, 5 stages
    logic [LIN_W-1:0] w_dist;

    gtg_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_big  (r_big),
        .i_d2   (r_d2lo),
        .o_dist (w_dist)
    );

    // hold distance and stop decision until the angles arrive
    logic [LIN_W-1:0] r_dl_dist [DLY];
    logic             r_dl_mov  [DLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl_dist[0] <= w_dist;
            r_dl_mov[0]  <= {{(TOL_W-LIN_W){1'b0}}, w_dist} >= r_tol;
            for (int k = 1; k < DLY; k++) begin
                r_dl_dist[k] <= r_dl_dist[k-1];
                r_dl_mov[k]  <= r_dl_mov[k-1];
            end
        end
    end

    // yaw and bearing
    logic                    w_yaw_vld;
    logic                    w_brg_vld;
    logic signed [ANG_W-1:0] w_yaw;
    logic signed [ANG_W-1:0] w_brg;

    gtg_cordic u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v2),
        .i_y     (r_num),
        .i_x     (r_den),
        .o_vld   (w_yaw_vld),
        .o_ang   (w_yaw)
    );

    gtg_cordic u_brg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v2),
        .i_y     (r_by),
        .i_x     (r_bx),
        .o_vld   (w_brg_vld),
        .o_ang   (w_brg)
    );

    // output register
    logic                    r_out_vld;
    logic [LIN_W-1:0]        r_out_lin;
    logic signed [ANG_W-1:0] r_out_ang;
    logic                    r_out_mov;
    logic signed [ANG_W:0]   w_diff;

    assign w_en   = !r_out_vld || o_cmd.ready;
    assign w_diff = (ANG_W+1)'(w_brg) - (ANG_W+1)'(w_yaw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_yaw_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_mov <= r_dl_mov[DLY-1];
            r_out_lin <= r_dl_mov[DLY-1] ? r_dl_dist[DLY-1] : '0;
            r_out_ang <= r_dl_mov[DLY-1] ? w_diff[ANG_W-1:0] : '0;
        end
    end

    assign i_pose.ready       = w_en;
    assign o_cmd.valid        = r_out_vld;
    assign o_cmd.linear_speed = r_out_lin;
    assign o_cmd.angular_rate = r_out_ang;
    assign o_cmd.moving       = r_out_mov;

    // both angle pipes must carry the same beats
    `GTG_ASSERT_IMP(a_vld_pair, i_clk, i_rst_n, 1'b1, w_yaw_vld == w_brg_vld)
    // stopped beat is all zero
    `GTG_ASSERT_IMP(a_stop_zero, i_clk, i_rst_n, r_out_vld && !r_out_mov, r_out_lin == '0 && r_out_ang == '0)
    // moving beat never below tolerance or above half a metre
    `GTG_ASSERT_IMP(a_mov_tol, i_clk, i_rst_n, r_out_vld && r_out_mov, r_tol[TOL_W-1:LIN_W] == '0 && r_out_lin >= r_tol[LIN_W-1:0] && r_out_lin <= HALF_M)

endmodule

@@ tb/tb_top.sv @@
module tb_top
    import gtg_pkg::*;
;

    // Clock, reset and run limits
    localparam int            HALF_PERIOD = 4;
    localparam int            MAX_CYCLES  = 400000;
    localparam int            DRAIN_WAIT  = 40;   // comfortably past the core's pipeline latency
    // Index with no register behind it; the core must ignore writes to it
    localparam logic [1:0]    REG_NONE    = 2'd3;
    localparam longint        QUAT_ONE    = 16384;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
    } t_pose;

    typedef struct packed {
        logic [LIN_W-1:0]        linear_speed;
        logic signed [ANG_W-1:0] angular_rate;
        logic                    moving;
    } t_cmd;

    // One row of the directed table: a pose and, where obvious, its command
    typedef struct {
        t_pose p;
        bit    has_exp;
        t_cmd  e;
    } t_drow;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [POS_W-1:0] i_cfg_data;

    gtg_pose_if pose_if ();
    gtg_cmd_if  cmd_if ();

    go_to_goal_velocity_controller_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pose     (pose_if),
        .o_cmd      (cmd_if)
    );

    // Shadow copy of the goal and tolerance registers
    logic signed [POS_W-1:0] goal_x_q;
    logic signed [POS_W-1:0] goal_y_q;
    logic [TOL_W-1:0]        tol_q;

    t_cmd  cmd_pending[$];     // commands the core still owes us
    int    err_cnt    = 0;
    int    cycle_cnt  = 0;
    int    send_idle_pct = 0;
    int    stall_pct     = 0;

    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Fixed point helpers for the command predictor
    // ---------------------------------------------------------------
    function automatic longint sat_pos(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Vectoring CORDIC atan2, Q.20 accumulator rounded to Q3.13
    function automatic longint cordic_atan2(longint y, longint x);
        longint z, m, t, q, ax, ay;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q20) : -longint'(PI_Q20);
            x = -x;
            y = -y;
        end
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m  = (ax > ay) ? ax : ay;
        // scale up so the CORDIC has full precision
        while (m < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t = x;
            if (y >= 0) begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        q = (z + 64) >>> 7;
        if (q > longint'(PI_Q13)) q = longint'(PI_Q13);
        if (q < -longint'(PI_Q13)) q = -longint'(PI_Q13);
        return q;
    endfunction

    // Exact floor square root, digit by digit
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Velocity command for one pose under the current goal and tolerance
    function automatic t_cmd steer_cmd(t_pose p);
        longint dx, dy, ax, ay, num, den, yaw, brg, ang;
        longint qx, qy, qz, qw;
        longint unsigned d2, dlen;
        t_cmd c;
        dx = sat_pos(longint'(goal_x_q) - longint'(p.pos_x));
        dy = sat_pos(longint'(goal_y_q) - longint'(p.pos_y));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        d2 = longint'(ax) * longint'(ax);
        d2 = d2 + longint'(ay) * longint'(ay);
        // anything at or past half a metre is clamped
        dlen = (d2 >= (64'd1 << 30)) ? 64'd32768 : floor_sqrt(d2);
        c = '0;
        if (dlen >= longint'(tol_q)) begin
            qx  = longint'(p.quat_x);
            qy  = longint'(p.quat_y);
            qz  = longint'(p.quat_z);
            qw  = longint'(p.quat_w);
            num = 2 * (qw * qz + qx * qy);
            den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
            yaw = cordic_atan2(num, den);
            brg = cordic_atan2(dy, dx);
            ang = brg - yaw;        // no wrapping, by design
            c.linear_speed = dlen[LIN_W-1:0];
            c.angular_rate = ang[ANG_W-1:0];
            c.moving       = 1'b1;
        end
        return c;
    endfunction

    // ---------------------------------------------------------------
    // Command sink: random backpressure, checking at the rising edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        cmd_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_cmd got, want;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            got.linear_speed = cmd_if.linear_speed;
            got.angular_rate = cmd_if.angular_rate;
            got.moving       = cmd_if.moving;
            if (cmd_pending.size() == 0) begin
                $error("unexpected command beat: lin %0d ang %0d moving %0d",
                       got.linear_speed, got.angular_rate, got.moving);
                err_cnt++;
            end else begin
                want = cmd_pending.pop_front();
                if (got.linear_speed !== want.linear_speed) begin
                    $error("linear_speed: expected %0d, got %0d",
                           want.linear_speed, got.linear_speed);
                    err_cnt++;
                end
                if (got.angular_rate !== want.angular_rate) begin
                    $error("angular_rate: expected %0d, got %0d",
                           want.angular_rate, got.angular_rate);
                    err_cnt++;
                end
                if (got.moving !== want.moving) begin
                    $error("moving: expected %0d, got %0d", want.moving, got.moving);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driver side
    // ---------------------------------------------------------------
    task automatic cfg_write(logic [1:0] idx, logic [POS_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            REG_GOAL_X: goal_x_q = data;
            REG_GOAL_Y: goal_y_q = data;
            REG_TOL:    tol_q    = data[TOL_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every owed command is out, then let the pipe settle
    task automatic drain();
        while (cmd_pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Push one pose beat; returns at the falling edge after acceptance.
    // A typed command, if given, overrides the predictor and is cross checked.
    task automatic send_pose(t_pose p, bit has_exp, t_cmd e);
        t_cmd pred;
        while ($urandom_range(99) < send_idle_pct) begin
            pose_if.valid = 1'b0;
            @(negedge i_clk);
        end
        pose_if.pos_x  = p.pos_x;
        pose_if.pos_y  = p.pos_y;
        pose_if.quat_x = p.quat_x;
        pose_if.quat_y = p.quat_y;
        pose_if.quat_z = p.quat_z;
        pose_if.quat_w = p.quat_w;
        pose_if.valid  = 1'b1;
        do @(posedge i_clk); while (!pose_if.ready);
        pred = steer_cmd(p);
        if (has_exp && pred !== e) begin
            $error("predictor: expected %h, table says %h", pred, e);
            err_cnt++;
        end
        cmd_pending.push_back(has_exp ? e : pred);
        @(negedge i_clk);
        pose_if.valid = 1'b0;
    endtask

    function automatic logic [QUAT_W-1:0] rand_quat();
        // mostly inside the unit range, sometimes any bit pattern
        if ($urandom_range(99) < 60) return QUAT_W'($urandom_range(32768) - 16384);
        return QUAT_W'($urandom);
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        int    mode;
        mode = $urandom_range(99);
        if (mode < 50) begin
            // close to the goal: straddles the half metre clamp and the tolerance
            p.pos_x = goal_x_q + POS_W'($urandom_range(80000) - 40000);
            p.pos_y = goal_y_q + POS_W'($urandom_range(80000) - 40000);
        end else if (mode < 70) begin
            p.pos_x = goal_x_q + POS_W'($urandom_range(2097152) - 1048576);
            p.pos_y = goal_y_q + POS_W'($urandom_range(2097152) - 1048576);
        end else begin
            p.pos_x = POS_W'($urandom);
            p.pos_y = POS_W'($urandom);
        end
        p.quat_x = rand_quat();
        p.quat_y = rand_quat();
        p.quat_z = rand_quat();
        p.quat_w = rand_quat();
        // now and then a quaternion that zeroes both yaw operands
        if ($urandom_range(99) < 3) begin
            p.quat_x = '0;
            p.quat_w = '0;
            p.quat_y = 16'sd8192;
            p.quat_z = ($urandom_range(1) != 0) ? 16'sd8192 : -16'sd8192;
        end
        return p;
    endfunction

    task automatic run_random(int n);
        t_cmd none;
        none = '0;
        repeat (n) send_pose(rand_pose(), 1'b0, none);
    endtask

    // Directed table, run under reset values of the registers
    t_drow dtab[$];

    function automatic t_drow mk_row(longint px, longint py, longint qx, longint qy,
                                     longint qz, longint qw, bit has_exp, t_cmd e);
        t_drow r;
        r.p.pos_x  = POS_W'(px);
        r.p.pos_y  = POS_W'(py);
        r.p.quat_x = QUAT_W'(qx);
        r.p.quat_y = QUAT_W'(qy);
        r.p.quat_z = QUAT_W'(qz);
        r.p.quat_w = QUAT_W'(qw);
        r.has_exp  = has_exp;
        r.e        = e;
        return r;
    endfunction

    initial begin
        t_cmd at_goal, none;
        at_goal = '{linear_speed: '0, angular_rate: '0, moving: 1'b1};
        none    = '0;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_GOAL_X;
        i_cfg_data   = '0;
        pose_if.valid  = 1'b0;
        pose_if.pos_x  = '0;
        pose_if.pos_y  = '0;
        pose_if.quat_x = '0;
        pose_if.quat_y = '0;
        pose_if.quat_z = '0;
        pose_if.quat_w = '0;
        cmd_if.ready   = 1'b1;
        goal_x_q = '0;
        goal_y_q = '0;
        tol_q    = '0;

        // At the goal with identity orientation: zero speed, zero turn, still moving
        dtab.push_back(mk_row(0, 0, 0, 0, 0, QUAT_ONE, 1'b1, at_goal));
        // At the goal with both yaw operands zero: angle comes out zero
        dtab.push_back(mk_row(0, 0, 0, 8192, 8192, 0, 1'b1, at_goal));
        dtab.push_back(mk_row(0, 0, 0, 8192, -8192, 0, 1'b1, at_goal));
        // At the goal, turned: rate is minus the yaw
        dtab.push_back(mk_row(0, 0, 0, 0, QUAT_ONE, 0, 1'b0, none));
        dtab.push_back(mk_row(0, 0, 0, 0, 11585, 11585, 1'b0, none));
        dtab.push_back(mk_row(0, 0, 0, 0, -11585, 11585, 1'b0, none));
        // Position extremes: saturating differences, clamped distance
        dtab.push_back(mk_row(2147483647, 2147483647, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(-2147483648, -2147483648, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(2147483647, -2147483648, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(-65536, 0, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(65536, 0, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(0, 65536, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(0, -65536, 0, 0, 0, QUAT_ONE, 1'b0, none));
        // Right at the clamp edge and just inside it
        dtab.push_back(mk_row(-32768, 0, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(-32767, 0, 0, 0, 0, QUAT_ONE, 1'b0, none));
        dtab.push_back(mk_row(-1, -1, 0, 0, 0, QUAT_ONE, 1'b0, none));
        // Quaternion extremes, non-unit and out of range patterns
        dtab.push_back(mk_row(1000, 2000, 16384, 16384, 16384, 16384, 1'b0, none));
        dtab.push_back(mk_row(1000, 2000, -16384, -16384, -16384, -16384, 1'b0, none));
        dtab.push_back(mk_row(-5000, 7000, -32768, -32768, -32768, -32768, 1'b0, none));
        dtab.push_back(mk_row(-5000, 7000, 32767, 32767, 32767, 32767, 1'b0, none));
        dtab.push_back(mk_row(3000, -3000, 32767, -32768, 32767, -32768, 1'b0, none));
        dtab.push_back(mk_row(3000, 3000, 0, 0, 0, 0, 1'b0, none));

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Phase 0: reset register values, directed table, free flowing
        send_idle_pct = 0;
        stall_pct     = 0;
        foreach (dtab[k]) send_pose(dtab[k].p, dtab[k].has_exp, dtab[k].e);
        run_random(80);
        drain();

        // Phase 1: goal at the positive corner, zero tolerance, bursty sender
        cfg_write(REG_GOAL_X, 32'h7fff_ffff);
        cfg_write(REG_GOAL_Y, 32'h7fff_ffff);
        cfg_write(REG_TOL, 32'h0);
        send_idle_pct = 60;
        stall_pct     = 0;
        run_random(110);
        drain();

        // Phase 2: negative corner, largest tolerance so nothing ever moves
        cfg_write(REG_GOAL_X, 32'h8000_0000);
        cfg_write(REG_GOAL_Y, 32'h8000_0000);
        cfg_write(REG_TOL, 32'h7fff_ffff);
        send_idle_pct = 0;
        stall_pct     = 60;
        run_random(110);
        drain();

        // Phase 3: random goal, tolerance inside the clamp; a write to a hole
        cfg_write(REG_GOAL_X, $urandom);
        cfg_write(REG_GOAL_Y, $urandom);
        cfg_write(REG_TOL, 32'd20000);
        cfg_write(REG_NONE, $urandom);
        send_idle_pct = 12;
        stall_pct     = 12;
        run_random(120);
        drain();

        // Phase 4: small random tolerance, no idling
        cfg_write(REG_GOAL_X, $urandom);
        cfg_write(REG_GOAL_Y, $urandom);
        cfg_write(REG_TOL, $urandom & 32'h0000_7fff);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(120);
        drain();

        // Phase 5: tolerance exactly half a metre, stalling receiver
        cfg_write(REG_GOAL_X, $urandom);
        cfg_write(REG_GOAL_Y, $urandom);
        cfg_write(REG_TOL, 32'd32768);
        send_idle_pct = 0;
        stall_pct     = 60;
        run_random(120);
        drain();

        // Phase 6: any tolerance bit pattern, both sides idling
        cfg_write(REG_GOAL_X, $urandom);
        cfg_write(REG_GOAL_Y, $urandom);
        cfg_write(REG_TOL, ($urandom_range(1) != 0) ? ($urandom & 32'h7fff_ffff)
                                                    : ($urandom & 32'h0000_ffff));
        send_idle_pct = 12;
        stall_pct     = 12;
        run_random(120);
        drain();

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ go_to_goal_velocity_controller_core.f @@
+incdir+rtl
rtl/gtg_pkg.sv
rtl/gtg_pose_if.sv
rtl/gtg_cmd_if.sv
rtl/gtg_sqrt.sv
rtl/gtg_cordic.sv
rtl/go_to_goal_velocity_controller_core.sv
tb/tb_top.sv
